### sv/matrix_multiply_top_macros.svh
// Assertion macros for the matrix multiply block.
`ifndef MATRIX_MULTIPLY_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MM_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define MM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define MM_ASSERT_NOW(lbl, pre, post, msg)
`define MM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/mm_pkg.sv
// Types and constants shared by the matrix multiply modules.
package mm_pkg;
	localparam int SUM_W = 67;
	localparam int DIM_W = 4;
	localparam int IX_W = 3;

	typedef enum logic [1:0] {
		MODE_LOAD_A  = 2'd0,
		MODE_LOAD_B  = 2'd1,
		MODE_COMPUTE = 2'd2,
		MODE_NONE    = 2'd3
	} mm_mode_t;

	localparam logic [1:0] CFG_ROWS_A = 2'd0;
	localparam logic [1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [1:0] CFG_COLS_B = 2'd2;

	typedef struct packed {
		logic            valid;
		logic [IX_W-1:0] r;
		logic [IX_W-1:0] c;
		logic            last;
	} mm_tok_t;

	typedef struct packed {
		logic            a_en;
		logic            b_en;
		logic [IX_W-1:0] row;
		logic [IX_W-1:0] col;
		logic [31:0]     data;
	} mm_wr_t;
endpackage

### sv/mm_cell.sv
// One dot product chain cell: holds column K of A and row K of B; adds a product if K < nk.
module mm_cell #(
	parameter int MAX_DIM = 8,
	parameter int K = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [mm_pkg::DIM_W-1:0]      nk,
	input  mm_pkg::mm_wr_t                wr,
	input  mm_pkg::mm_tok_t               tok_in,
	input  logic signed [mm_pkg::SUM_W-1:0] sum_in,
	output mm_pkg::mm_tok_t               tok_out,
	output logic signed [mm_pkg::SUM_W-1:0] sum_out
);
	import mm_pkg::*;

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [31:0] mem_a [MAX_DIM];
	logic [31:0] mem_b [MAX_DIM];

	mm_tok_t tok_s1, tok_s2, tok_s3;
	logic signed [SUM_W-1:0] sum_s1, sum_s2, sum_s3;
	logic signed [31:0] a_s1, b_s1;
	logic signed [63:0] prod_s2;
	logic active;

	assign active = (DIM_W'(K) < nk);

	always_ff @(posedge clk) begin
		if (wr.a_en && wr.col == IX_W'(K)) begin
			mem_a[wr.row[IDX_W-1:0]] <= wr.data;
		end
		if (wr.b_en && wr.row == IX_W'(K)) begin
			mem_b[wr.col[IDX_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= mem_a[tok_in.r[IDX_W-1:0]];
			b_s1 <= mem_b[tok_in.c[IDX_W-1:0]];
			sum_s1 <= sum_in;
			prod_s2 <= a_s1 * b_s1;
			sum_s2 <= sum_s1;
			sum_s3 <= active ? sum_s2 + SUM_W'(prod_s2) : sum_s2;
		end
	end

	assign tok_out = tok_s3;
	assign sum_out = sum_s3;
endmodule

### sv/mm_seq.sv
// Sequencer that walks the product elements in row-major order and feeds the cell chain.
module mm_seq #(
	parameter int MAX_DIM = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     adv,
	input  logic [mm_pkg::DIM_W-1:0] rows_a,
	input  logic [mm_pkg::DIM_W-1:0] inner_dim,
	input  logic [mm_pkg::DIM_W-1:0] cols_b,
	output logic [mm_pkg::DIM_W-1:0] nk,
	output mm_pkg::mm_tok_t          tok,
	output logic                     issuing
);
	import mm_pkg::*;

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	logic issuing_q;
	logic [IX_W-1:0] r_q, c_q;
	logic [DIM_W-1:0] nr_q, nk_q, nc_q;
	logic r_end, c_end;

	function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] res;
		res = v;
		if (v == '0) res = DIM_W'(1);
		if (v > DIM_MAX) res = DIM_MAX;
		return res;
	endfunction

	assign r_end = ({1'b0, r_q} + DIM_W'(1)) == nr_q;
	assign c_end = ({1'b0, c_q} + DIM_W'(1)) == nc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			nr_q <= DIM_MAX;
			nk_q <= DIM_MAX;
			nc_q <= DIM_MAX;
		end else if (start) begin
			issuing_q <= 1'b1;
			r_q <= '0;
			c_q <= '0;
			nr_q <= clamp(rows_a);
			nk_q <= clamp(inner_dim);
			nc_q <= clamp(cols_b);
		end else if (adv && issuing_q) begin
			if (c_end) begin
				c_q <= '0;
				r_q <= r_q + IX_W'(1);
				if (r_end) begin
					issuing_q <= 1'b0;
				end
			end else begin
				c_q <= c_q + IX_W'(1);
			end
		end
	end

	always_comb begin
		tok.valid = issuing_q;
		tok.r = r_q;
		tok.c = c_q;
		tok.last = r_end && c_end;
	end

	assign nk = nk_q;
	assign issuing = issuing_q;
endmodule

### sv/matrix_multiply_top.sv
// Matrix multiply top level: request handshakes, configuration, cell chain and output register.
// Load requests are accepted back to back.
// A compute request gives one result per cycle while out_ready does not stall.
// Its results pass through the chain of MAX_DIM cells, three stages each; a stall on out_ready freezes the chain.
// New requests wait until the last result of a compute request has been taken.
// Reset clears control and sets the configured dimensions to 8; the element stores are undefined until written.
module matrix_multiply_top #(
	parameter int MAX_DIM = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic [2:0]               row,
	input  logic [2:0]               col,
	input  logic signed [31:0]       value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               out_row,
	output logic [2:0]               out_col,
	output logic signed [31:0]       product,
	output logic                     last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [mm_pkg::DIM_W-1:0] cfg_data
);
	import mm_pkg::*;
	`include "matrix_multiply_top_macros.svh"

	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q, nk;
	logic busy_q, adv, accept, start, in_range, issuing;
	mm_wr_t wr;
	mm_tok_t tok [MAX_DIM+1];
	logic signed [SUM_W-1:0] sum [MAX_DIM+1];
	logic out_valid_q, last_q;
	logic [2:0] out_row_q, out_col_q;
	logic [31:0] product_q, sat;
	logic [SUM_W-17:0] sh;

	assign in_ready = !busy_q;
	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign start = accept && mode == MODE_COMPUTE;
	assign adv = !out_valid_q || out_ready;
	assign in_range = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);

	always_comb begin
		wr.a_en = accept && in_range && mode == MODE_LOAD_A;
		wr.b_en = accept && in_range && mode == MODE_LOAD_B;
		wr.row = row;
		wr.col = col;
		wr.data = value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(8);
			inner_dim_q <= DIM_W'(8);
			cols_b_q <= DIM_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROWS_A: rows_a_q <= cfg_data;
				CFG_INNER_DIM: inner_dim_q <= cfg_data;
				CFG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .adv(adv),
		.rows_a(rows_a_q), .inner_dim(inner_dim_q), .cols_b(cols_b_q),
		.nk(nk), .tok(tok[0]), .issuing(issuing)
	);

	assign sum[0] = '0;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		mm_cell #(.MAX_DIM(MAX_DIM), .K(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv), .nk(nk), .wr(wr),
			.tok_in(tok[k]), .sum_in(sum[k]),
			.tok_out(tok[k+1]), .sum_out(sum[k+1])
		);
	end

	always_comb begin
		sh = sum[MAX_DIM][SUM_W-1:16];
		if ((&sh[SUM_W-17:31]) || !(|sh[SUM_W-17:31])) begin
			sat = sh[31:0];
		end else if (sh[SUM_W-17]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= tok[MAX_DIM].valid;
			end
			if (start) begin
				busy_q <= 1'b1;
			end else if (out_valid_q && out_ready && last_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_row_q <= tok[MAX_DIM].r;
			out_col_q <= tok[MAX_DIM].c;
			last_q <= tok[MAX_DIM].last;
			product_q <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign product = product_q;
	assign last = last_q;

	`MM_ASSERT_NOW(a_result_only_busy, out_valid_q, busy_q, "result outside a compute request")
	`MM_ASSERT_NEXT(a_start_issues, start, issuing, "compute request did not start the sequencer")
	`MM_ASSERT_NEXT(a_last_ends_busy, out_valid_q && out_ready && last_q, !busy_q,
		"block still busy after the final result")
endmodule
